[design/ifd_pkg.sv]
`default_nettype none

package ifd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SqW     = 31;  // (-32768)^2 = 2^30
  localparam int unsigned MagW    = 32;  // three squares stay below 2^32
  localparam int unsigned CountW  = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_FREEFALL    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMPACT      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROTATION    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MOTION_ACC  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MOTION_RATE = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_STILL       = 3'd5;

  localparam logic [MagW-1:0]   RST_FREEFALL    = 32'd2516582;
  localparam logic [MagW-1:0]   RST_IMPACT      = 32'd11744051;
  localparam logic [MagW-1:0]   RST_ROTATION    = 32'd10758400;
  localparam logic [MagW-1:0]   RST_MOTION_ACC  = 32'd6291456;
  localparam logic [MagW-1:0]   RST_MOTION_RATE = 32'd672400;
  localparam logic [CountW-1:0] RST_STILL       = 10'd100;

  typedef enum logic [2:0] {
    PH_NORMAL   = 3'd0,
    PH_FREEFALL = 3'd1,
    PH_IMPACT   = 3'd2,
    PH_ROTATION = 3'd3,
    PH_STILL    = 3'd4
  } phase_t;

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
    logic signed [SampleW-1:0] rate_x;
    logic signed [SampleW-1:0] rate_y;
    logic signed [SampleW-1:0] rate_z;
  } sample_t;

  typedef struct packed {
    logic [SqW-1:0] ax2;
    logic [SqW-1:0] ay2;
    logic [SqW-1:0] az2;
    logic [SqW-1:0] gx2;
    logic [SqW-1:0] gy2;
    logic [SqW-1:0] gz2;
    logic           tilt;
  } sq_t;

  typedef struct packed {
    logic [MagW-1:0]   freefall_thr;
    logic [MagW-1:0]   impact_thr;
    logic [MagW-1:0]   rotation_thr;
    logic [MagW-1:0]   motion_acc_thr;
    logic [MagW-1:0]   motion_rate_thr;
    logic [CountW-1:0] still_samples;
  } cfg_t;

  typedef struct packed {
    logic en;    // stage register loads
    logic take;  // a request moves in, update state
  } adv_t;

endpackage

`default_nettype wire

[design/ifd_cfg_regs.sv]
`default_nettype none

module ifd_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [ifd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ifd_pkg::CfgW-1:0]     cfg_wdata,
  output ifd_pkg::cfg_t                     cfg
);

  ifd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.freefall_thr    <= ifd_pkg::RST_FREEFALL;
      cfg_r.impact_thr      <= ifd_pkg::RST_IMPACT;
      cfg_r.rotation_thr    <= ifd_pkg::RST_ROTATION;
      cfg_r.motion_acc_thr  <= ifd_pkg::RST_MOTION_ACC;
      cfg_r.motion_rate_thr <= ifd_pkg::RST_MOTION_RATE;
      cfg_r.still_samples   <= ifd_pkg::RST_STILL;
    end else if (cfg_we) begin
      case (cfg_index)
        ifd_pkg::CFG_FREEFALL:    cfg_r.freefall_thr    <= cfg_wdata;
        ifd_pkg::CFG_IMPACT:      cfg_r.impact_thr      <= cfg_wdata;
        ifd_pkg::CFG_ROTATION:    cfg_r.rotation_thr    <= cfg_wdata;
        ifd_pkg::CFG_MOTION_ACC:  cfg_r.motion_acc_thr  <= cfg_wdata;
        ifd_pkg::CFG_MOTION_RATE: cfg_r.motion_rate_thr <= cfg_wdata;
        ifd_pkg::CFG_STILL:       cfg_r.still_samples   <= cfg_wdata[ifd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[design/ifd_square.sv]
`default_nettype none

module ifd_square (
  input  wire logic  clk,
  input  wire logic  en,
  input  wire ifd_pkg::sample_t smp,
  output ifd_pkg::sq_t     sq
);

  ifd_pkg::sq_t sq_r;
  ifd_pkg::sq_t sq_nxt;

  logic signed [2*ifd_pkg::SampleW-1:0] p_ax, p_ay, p_az, p_gx, p_gy, p_gz;
  logic signed [ifd_pkg::SampleW:0]     ax_e, ay_e, az_e;
  logic        [ifd_pkg::SampleW:0]     ax_mag, ay_mag;

  always_comb begin
    p_ax = smp.accel_x * smp.accel_x;
    p_ay = smp.accel_y * smp.accel_y;
    p_az = smp.accel_z * smp.accel_z;
    p_gx = smp.rate_x * smp.rate_x;
    p_gy = smp.rate_y * smp.rate_y;
    p_gz = smp.rate_z * smp.rate_z;

    // tilt above 45 deg: |ax| > az or |ay| > az, compared on 18 signed bits
    ax_e   = {smp.accel_x[ifd_pkg::SampleW-1], smp.accel_x};
    ay_e   = {smp.accel_y[ifd_pkg::SampleW-1], smp.accel_y};
    az_e   = {smp.accel_z[ifd_pkg::SampleW-1], smp.accel_z};
    ax_mag = ax_e[ifd_pkg::SampleW] ? 17'(-ax_e) : 17'(ax_e);
    ay_mag = ay_e[ifd_pkg::SampleW] ? 17'(-ay_e) : 17'(ay_e);

    sq_nxt.ax2  = p_ax[ifd_pkg::SqW-1:0];
    sq_nxt.ay2  = p_ay[ifd_pkg::SqW-1:0];
    sq_nxt.az2  = p_az[ifd_pkg::SqW-1:0];
    sq_nxt.gx2  = p_gx[ifd_pkg::SqW-1:0];
    sq_nxt.gy2  = p_gy[ifd_pkg::SqW-1:0];
    sq_nxt.gz2  = p_gz[ifd_pkg::SqW-1:0];
    sq_nxt.tilt = ($signed({1'b0, ax_mag}) > $signed({az_e[ifd_pkg::SampleW], az_e})) ||
                  ($signed({1'b0, ay_mag}) > $signed({az_e[ifd_pkg::SampleW], az_e}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

[design/ifd_phase.sv]
`default_nettype none

module ifd_phase (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire ifd_pkg::adv_t adv,
  input  wire ifd_pkg::sq_t  sq,
  input  wire ifd_pkg::cfg_t cfg,
  output ifd_pkg::phase_t phase,
  output logic          fall_flag
);

  ifd_pkg::phase_t phase_r, phase_nxt;
  logic [ifd_pkg::CountW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                       fall_r, fall_nxt;
  logic [ifd_pkg::MagW-1:0]   acc, gyr;
  logic                       motion, done;

  always_comb begin
    acc = {1'b0, sq.ax2} + {1'b0, sq.ay2} + {1'b0, sq.az2};
    gyr = {1'b0, sq.gx2} + {1'b0, sq.gy2} + {1'b0, sq.gz2};
    cnt_inc = cnt_r + 1'b1;
    motion  = (acc > cfg.motion_acc_thr) || (gyr > cfg.motion_rate_thr);
    done    = cnt_inc >= cfg.still_samples;
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      ifd_pkg::PH_FREEFALL: if (acc > cfg.impact_thr)   phase_nxt = ifd_pkg::PH_IMPACT;
      ifd_pkg::PH_IMPACT:   if (gyr > cfg.rotation_thr) phase_nxt = ifd_pkg::PH_ROTATION;
      ifd_pkg::PH_ROTATION: if (sq.tilt)                phase_nxt = ifd_pkg::PH_STILL;
      ifd_pkg::PH_STILL:    if (motion || done)         phase_nxt = ifd_pkg::PH_NORMAL;
      default: phase_nxt = (acc < cfg.freefall_thr) ? ifd_pkg::PH_FREEFALL
                                                    : ifd_pkg::PH_NORMAL;
    endcase
  end

  // count and flag
  always_comb begin
    cnt_nxt  = cnt_r;
    fall_nxt = 1'b0;
    case (phase_r)
      ifd_pkg::PH_ROTATION: if (sq.tilt) cnt_nxt = '0;
      ifd_pkg::PH_STILL: begin
        if (motion) begin
          cnt_nxt = '0;
        end else if (done) begin
          cnt_nxt  = '0;
          fall_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ifd_pkg::PH_NORMAL;
      cnt_r   <= '0;
    end else if (adv.take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en) begin
      fall_r <= fall_nxt;
    end
  end

  assign phase     = phase_r;
  assign fall_flag = fall_r;

endmodule

`default_nettype wire

[design/imu_fall_detector_unit.sv]
// Pipeline: input, square and result registers; out_valid comes from the result stage.
// Throughput: one sample per cycle while out_stall is low; the phase and still count
// update in the result stage, behind one register of 16x16 squares.
// Reset (rst_n low, synchronous): pipeline emptied, phase normal, still count zero,
// thresholds back to their defaults.
`default_nettype none

module imu_fall_detector_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [15:0]           in_accel_x,
  input  wire logic signed [15:0]           in_accel_y,
  input  wire logic signed [15:0]           in_accel_z,
  input  wire logic signed [15:0]           in_rate_x,
  input  wire logic signed [15:0]           in_rate_y,
  input  wire logic signed [15:0]           in_rate_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_fall_flag,
  output logic [2:0]                        out_phase_now,
  input  wire logic                         cfg_we,
  input  wire logic [ifd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ifd_pkg::CfgW-1:0]     cfg_wdata
);

  ifd_pkg::sample_t smp_r;
  ifd_pkg::sq_t     sq;
  ifd_pkg::cfg_t    cfg;
  ifd_pkg::adv_t    adv_out;
  ifd_pkg::phase_t  phase;
  logic v0_r, v1_r, v2_r;
  logic en0, en1, en2;

  // each stage moves when it is empty or its successor is moving
  assign en2 = !v2_r || !out_stall;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_stall = !en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      smp_r.accel_x <= in_accel_x;
      smp_r.accel_y <= in_accel_y;
      smp_r.accel_z <= in_accel_z;
      smp_r.rate_x  <= in_rate_x;
      smp_r.rate_y  <= in_rate_y;
      smp_r.rate_z  <= in_rate_z;
    end
  end

  assign adv_out.en   = en2;
  assign adv_out.take = en2 && v1_r;

  ifd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifd_square u_square (
    .clk (clk),
    .en  (en1),
    .smp (smp_r),
    .sq  (sq)
  );

  ifd_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv_out),
    .sq        (sq),
    .cfg       (cfg),
    .phase     (phase),
    .fall_flag (out_fall_flag)
  );

  assign out_valid     = v2_r;
  assign out_phase_now = phase;

  // a flagged fall always lands back in normal
  a_fall_to_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fall_flag) |-> (out_phase_now == ifd_pkg::PH_NORMAL))
    else $error("fall flagged outside normal phase");

  // a fall only follows a still phase
  a_fall_from_still: assert property (@(posedge clk) disable iff (!rst_n)
    adv_out.take |=> (!out_fall_flag || $past(phase) == ifd_pkg::PH_STILL))
    else $error("fall flagged without still phase");

  // phase only moves when a request reaches the result stage
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv_out.take |=> $stable(phase))
    else $error("phase changed without a request");

  // stall back to the input only when every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && out_stall))
    else $error("input stalled with an empty stage");

endmodule

`default_nettype wire

[tb/sv/imu_fall_detector_unit_tb.sv]
`default_nettype none

module imu_fall_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifd_pkg::*;

  // writes to these land nowhere
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_B = 3'd7;
  localparam logic [CfgW-1:0]    THR_MAX      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic   flag;
    phase_t phase;
  } verdict_t;

  class fall_tracker;
    cfg_t              cfg;
    phase_t            phase;
    logic [CountW-1:0] quiet_cnt;
    verdict_t          verdicts[$];
    int                errors;
    int                seen;

    function new();
      cfg = '{RST_FREEFALL, RST_IMPACT, RST_ROTATION, RST_MOTION_ACC, RST_MOTION_RATE,
              RST_STILL};
      phase = PH_NORMAL;
      quiet_cnt = '0;
      errors = 0;
      seen = 0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_FREEFALL:    cfg.freefall_thr = data;
        CFG_IMPACT:      cfg.impact_thr = data;
        CFG_ROTATION:    cfg.rotation_thr = data;
        CFG_MOTION_ACC:  cfg.motion_acc_thr = data;
        CFG_MOTION_RATE: cfg.motion_rate_thr = data;
        CFG_STILL:       cfg.still_samples = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    // one request in, one verdict expected
    function void take_sample(sample_t s);
      int     ax, ay, az, gx, gy, gz, mx, my;
      longint acc, gyr;
      logic   flag;
      ax = $signed(s.accel_x);
      ay = $signed(s.accel_y);
      az = $signed(s.accel_z);
      gx = $signed(s.rate_x);
      gy = $signed(s.rate_y);
      gz = $signed(s.rate_z);
      acc = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
      gyr = longint'(gx) * gx + longint'(gy) * gy + longint'(gz) * gz;
      mx = (ax < 0) ? -ax : ax;
      my = (ay < 0) ? -ay : ay;
      flag = 1'b0;
      case (phase)
        PH_FREEFALL: begin
          if (acc > longint'(cfg.impact_thr)) phase = PH_IMPACT;
        end
        PH_IMPACT: begin
          if (gyr > longint'(cfg.rotation_thr)) phase = PH_ROTATION;
        end
        PH_ROTATION: begin
          // tilt past 45 degrees on either axis
          if (mx > az || my > az) begin
            phase = PH_STILL;
            quiet_cnt = '0;
          end
        end
        PH_STILL: begin
          quiet_cnt = quiet_cnt + 1'b1;
          if (acc > longint'(cfg.motion_acc_thr) || gyr > longint'(cfg.motion_rate_thr)) begin
            phase = PH_NORMAL;
            quiet_cnt = '0;
          end else if (quiet_cnt >= cfg.still_samples) begin
            phase = PH_NORMAL;
            quiet_cnt = '0;
            flag = 1'b1;
          end
        end
        default: begin
          phase = (acc < longint'(cfg.freefall_thr)) ? PH_FREEFALL : PH_NORMAL;
        end
      endcase
      verdicts.push_back('{flag, phase});
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(logic flag, logic [2:0] ph);
      verdict_t v;
      seen++;
      if (verdicts.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", seen));
        return;
      end
      v = verdicts.pop_front();
      if (flag !== v.flag)
        report($sformatf("result %0d fall_flag %b, want %b", seen, flag, v.flag));
      if (ph !== v.phase)
        report($sformatf("result %0d phase_now %0d, want %0d", seen, ph, v.phase));
    endtask

    task flush();
      if (verdicts.size() != 0)
        report($sformatf("%0d results never arrived", verdicts.size()));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic signed [15:0] in_rate_x = '0;
  logic signed [15:0] in_rate_y = '0;
  logic signed [15:0] in_rate_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_fall_flag;
  logic [2:0]         out_phase_now;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;

  fall_tracker tracker = new();
  bit          calm = 1'b0;
  int          sent = 0;
  int          stall_left = 0;

  imu_fall_detector_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_rate_x     (in_rate_x),
    .in_rate_y     (in_rate_y),
    .in_rate_z     (in_rate_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_fall_flag (out_fall_flag),
    .out_phase_now (out_phase_now),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random bursts of stall or free running
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 10);
    end
  end

  // inputs only move at rising edges, so the falling edge sees what the next edge takes
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_verdict(out_fall_flag, out_phase_now);
  end

  function automatic sample_t sample_of(input int ax, input int ay, input int az,
                                        input int gx, input int gy, input int gz);
    sample_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.rate_x = 16'(gx);
    s.rate_y = 16'(gy);
    s.rate_z = 16'(gz);
    return s;
  endfunction

  // per-axis bound that keeps a sum of three squares at or below thr
  function automatic int lim_under(logic [CfgW-1:0] thr);
    real r;
    r = $sqrt(real'(thr) / 3.0);
    if (r > 32767.0) return 32767;
    return int'($floor(r));
  endfunction

  function automatic int pick(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // one axis alone beats thr where the range allows it
  function automatic int pick_loud(logic [CfgW-1:0] thr);
    int lo, v;
    lo = int'($ceil($sqrt(real'(thr)))) + 1;
    if (lo > 32767) lo = 32767;
    v = $urandom_range(lo, 32767);
    if (v == 32767 && $urandom_range(0, 1)) return -32768;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic send_sample(input sample_t s);
    bit held;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= s.accel_x;
    in_accel_y <= s.accel_y;
    in_accel_z <= s.accel_z;
    in_rate_x <= s.rate_x;
    in_rate_y <= s.rate_y;
    in_rate_z <= s.rate_z;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    tracker.take_sample(s);
    sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t c);
    write_reg(CFG_FREEFALL, c.freefall_thr);
    write_reg(CFG_IMPACT, c.impact_thr);
    write_reg(CFG_ROTATION, c.rotation_thr);
    write_reg(CFG_MOTION_ACC, c.motion_acc_thr);
    write_reg(CFG_MOTION_RATE, c.motion_rate_thr);
    write_reg(CFG_STILL, CfgW'(c.still_samples));
    write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [CfgW-1:0] rand_thr(logic [CfgW-1:0] nominal);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return THR_MAX;
    return $urandom_range(nominal / 2, nominal * 2);
  endfunction

  // normal, free fall, impact, rotation, tilt, then a run of stillness
  task automatic run_fall_sequence();
    cfg_t c;
    int   a, g, n, k, cut, az, m;
    c = tracker.cfg;
    repeat ($urandom_range(1, 3))
      send_sample(sample_of(pick(4096), pick(4096), pick(4096), pick(2000), pick(2000),
                            pick(2000)));
    a = lim_under(c.freefall_thr);
    repeat ($urandom_range(1, 3))
      send_sample(sample_of(pick(a), pick(a), pick(a), pick(3000), pick(3000), pick(3000)));
    repeat ($urandom_range(1, 2)) begin
      k = $urandom_range(0, 2);
      send_sample(sample_of(k == 0 ? pick_loud(c.impact_thr) : pick(2048),
                            k == 1 ? pick_loud(c.impact_thr) : pick(2048),
                            k == 2 ? pick_loud(c.impact_thr) : pick(2048),
                            pick(3000), pick(3000), pick(3000)));
    end
    repeat ($urandom_range(1, 2)) begin
      k = $urandom_range(0, 2);
      send_sample(sample_of(pick(4096), pick(4096), pick(4096),
                            k == 0 ? pick_loud(c.rotation_thr) : pick(2000),
                            k == 1 ? pick_loud(c.rotation_thr) : pick(2000),
                            k == 2 ? pick_loud(c.rotation_thr) : pick(2000)));
    end
    // sometimes upright first, which leaves the rotation phase waiting
    if ($urandom_range(0, 7) == 0) begin
      az = $urandom_range(0, 2048);
      send_sample(sample_of(pick(az), pick(az), az, pick(800), pick(800), pick(800)));
    end
    az = int'($urandom_range(0, 4096)) - 2048;
    m = ((az < 0) ? -az : az) + 1 + int'($urandom_range(0, 1000));
    if ($urandom_range(0, 1) == 0) m = -m;
    if ($urandom_range(0, 1))
      send_sample(sample_of(m, pick(1000), az, pick(800), pick(800), pick(800)));
    else
      send_sample(sample_of(pick(1000), m, az, pick(800), pick(800), pick(800)));
    a = lim_under(c.motion_acc_thr);
    g = lim_under(c.motion_rate_thr);
    n = int'(c.still_samples) + int'($urandom_range(0, 2));
    cut = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, n)) : -1;
    for (k = 0; k <= n; k++) begin
      if (k == cut) begin
        if ($urandom_range(0, 1))
          send_sample(sample_of(pick(a), pick_loud(c.motion_acc_thr), pick(a), pick(g),
                                pick(g), pick(g)));
        else
          send_sample(sample_of(pick(a), pick(a), pick(a), pick(g),
                                pick_loud(c.motion_rate_thr), pick(g)));
      end else begin
        send_sample(sample_of(pick(a), pick(a), pick(a), pick(g), pick(g), pick(g)));
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("imu_fall_detector_unit_tb: done, errors");
    $finish;
  end

  initial begin
    cfg_t c;
    int   p, budget;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset thresholds, short still count
    write_reg(CFG_STILL, 2);
    cfg_we <= 1'b0;
    send_sample(sample_of(0, 0, 0, 0, 0, 0));
    send_sample(sample_of(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(sample_of(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(sample_of(0, 0, 2048, 0, 0, 0));
    send_sample(sample_of(2048, -2048, 2048, 0, 0, 0));  // |x| == z is not a tilt
    send_sample(sample_of(-2049, 0, 2048, 0, 0, 0));
    send_sample(sample_of(0, 0, 2048, 0, 0, 0));
    send_sample(sample_of(0, 0, 2048, 10, -10, 10));     // completes the fall
    send_sample(sample_of(0, 0, 2048, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 0, 0));
    send_sample(sample_of(32767, 0, 0, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, 0, 0, -32768));
    send_sample(sample_of(0, 100, -5, 0, 0, 0));
    send_sample(sample_of(0, 0, 2048, 900, 0, 0));       // motion cancels the still run
    in_valid <= 1'b0;
    drain();
    // a zero still count flags on the first quiet sample
    write_reg(CFG_STILL, 0);
    cfg_we <= 1'b0;
    send_sample(sample_of(100, -100, 0, 0, 0, 0));
    send_sample(sample_of(0, -32768, 0, 0, 0, 0));
    send_sample(sample_of(0, 0, 0, -32768, 0, 0));
    send_sample(sample_of(0, 0, -32768, 0, 0, 0));
    send_sample(sample_of(0, 0, 2048, 0, 0, 0));
    in_valid <= 1'b0;

    for (p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: c = '{RST_FREEFALL, RST_IMPACT, RST_ROTATION, RST_MOTION_ACC, RST_MOTION_RATE,
                 RST_STILL};
        1: c = '{'0, '0, '0, '0, '0, 10'd1};
        2: c = '{THR_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX, 10'd5};
        3: c = '{THR_MAX, '0, '0, THR_MAX, THR_MAX, 10'd1};
        4: c = '{RST_FREEFALL, RST_IMPACT, RST_ROTATION, RST_MOTION_ACC, RST_MOTION_RATE,
                 10'd63};
        default: begin
          c.freefall_thr = rand_thr(RST_FREEFALL);
          c.impact_thr = rand_thr(RST_IMPACT);
          c.rotation_thr = rand_thr(RST_ROTATION);
          c.motion_acc_thr = rand_thr(RST_MOTION_ACC);
          c.motion_rate_thr = rand_thr(RST_MOTION_RATE);
          c.still_samples = CountW'($urandom_range(0, 12));
        end
      endcase
      load_setting(c);
      if (p == 9) calm = 1'b1;
      budget = sent + 70;
      while (sent < budget) begin
        if ($urandom_range(0, 4) == 0)
          send_sample(sample_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        else
          run_fall_sequence();
      end
      in_valid <= 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    tracker.flush();
    if (tracker.errors == 0)
      $display("imu_fall_detector_unit_tb: done, clean");
    else
      $display("imu_fall_detector_unit_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
